>>> hw/rtl/mtpp_pkg.sv
// Types and constants shared by the median threshold peak picker.
// Holds the request and response item layouts and the fixed field widths.
// No dependencies.
package mtpp_pkg;

   localparam int NOVELTY_W = 16;
   localparam int INDEX_W   = 12;
   localparam int SUPPRESS_W = 2;

   localparam logic [NOVELTY_W-1:0]  THRESHOLD_OFFSET_RESET = 16'd6554;
   localparam logic [SUPPRESS_W-1:0] SUPPRESS_SPAN          = 2'd3;

   typedef logic [NOVELTY_W-1:0] sample_type;

   // Five samples centered on a candidate, oldest in element 0.
   typedef sample_type [4:0] span_type;

   typedef struct packed {
      sample_type novelty;
      logic       last;
   } req_type;

   typedef struct packed {
      logic               peak_found;
      logic [INDEX_W-1:0] peak_index;
      logic               frame_done;
   } rsp_type;

endpackage

>>> hw/rtl/median_threshold_peak_picker_core.sv
// Median adaptive-threshold peak picker, top level.
// Depends on mtpp_pkg for the item types and constants.
//
// The core takes one novelty sample per item and returns exactly one result per item.
// Its result moves from the input register to the result register, held there while
// the result side stalls. A new item can be taken in every cycle unless the result side
// stalls with both registers full: the window and frame index advance as an item is
// accepted, the item's five-sample span is held in an input register, and the median
// networks, threshold compare and suppression counter sit between it and the result
// register, the counter being the only loop. The user must write threshold_offset
// through the csr port only while no item is in flight; the block does not enforce this.
module median_threshold_peak_picker_core
   import mtpp_pkg::*;
#(
   parameter int MAX_FRAMES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  sample_type csr_write_data
);

   localparam int CNT_W = $clog2(MAX_FRAMES);
   localparam int IDX_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_FRAMES - 1);

   function automatic sample_type median5(input span_type v);
      sample_type p0, p1, p2, p3, p4, t;
      p0 = v[0];
      p1 = v[1];
      p2 = v[2];
      p3 = v[3];
      p4 = v[4];
      if (p0 > p1) begin t = p0; p0 = p1; p1 = t; end
      if (p3 > p4) begin t = p3; p3 = p4; p4 = t; end
      if (p0 > p3) begin t = p0; p0 = p3; p3 = t; end
      if (p1 > p4) begin t = p1; p1 = p4; p4 = t; end
      if (p1 > p2) begin t = p1; p1 = p2; p2 = t; end
      if (p2 > p3) begin t = p2; p2 = p3; p3 = t; end
      if (p1 > p2) begin t = p1; p1 = p2; p2 = t; end
      return p2;
   endfunction

   function automatic logic peak_test(input span_type v, input sample_type offset);
      logic [NOVELTY_W:0] level;
      level = {1'b0, median5(v)} + {1'b0, offset};
      return (v[1] < v[2]) && (v[3] < v[2]) && ({1'b0, v[2]} > level);
   endfunction

   sample_type            offset_ff;
   sample_type            window_ff [4];
   logic [CNT_W-1:0]      count_ff;
   logic [SUPPRESS_W-1:0] suppress_ff, suppress_in;

   logic                  s1_valid_ff, s1_valid_in;
   span_type              s1_span_ff;
   logic [CNT_W-1:0]      s1_count_ff;
   logic                  s1_last_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_accept, out_move, s1_move;
   span_type              tail_span;
   logic                  elig_a, elig_b, test_a, test_b, found_a, found_b;
   logic [SUPPRESS_W-1:0] suppress_mid;
   logic [IDX_W-1:0]      count_ext;

   assign out_move   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_move;
   assign req_stall  = s1_valid_ff && !out_move;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !out_move);
   assign rsp_valid_in = out_move ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= THRESHOLD_OFFSET_RESET;
      end else if (csr_write_enable) begin
         offset_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            window_ff[k] <= '0;
         end
      end else if (req_accept) begin
         if (req_data.last) begin
            count_ff <= '0;
            for (int k = 0; k < 4; k++) begin
               window_ff[k] <= '0;
            end
         end else begin
            window_ff[0] <= req_data.novelty;
            window_ff[1] <= window_ff[0];
            window_ff[2] <= window_ff[1];
            window_ff[3] <= window_ff[2];
            if (count_ff < COUNT_MAX) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         suppress_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         suppress_ff  <= suppress_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_span_ff  <= {req_data.novelty, window_ff[0], window_ff[1],
                         window_ff[2], window_ff[3]};
         s1_count_ff <= count_ff;
         s1_last_ff  <= req_data.last;
      end
      if (out_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      tail_span = {{NOVELTY_W{1'b0}}, s1_span_ff[4], s1_span_ff[3],
                   s1_span_ff[2], s1_span_ff[1]};
      elig_a    = s1_count_ff >= CNT_W'(3);
      elig_b    = s1_last_ff && (s1_count_ff >= CNT_W'(2));
      test_a    = peak_test(s1_span_ff, offset_ff);
      test_b    = peak_test(tail_span, offset_ff);
      count_ext = IDX_W'(s1_count_ff);

      found_a      = 1'b0;
      suppress_mid = suppress_ff;
      if (elig_a) begin
         if (suppress_ff != '0) begin
            suppress_mid = suppress_ff - SUPPRESS_W'(1);
         end else if (test_a) begin
            found_a      = 1'b1;
            suppress_mid = SUPPRESS_SPAN;
         end
      end
      found_b = elig_b && (suppress_mid == '0) && test_b && !found_a;

      rsp_data_in.peak_found = found_a || found_b;
      rsp_data_in.frame_done = s1_last_ff;
      if (found_a) begin
         rsp_data_in.peak_index = INDEX_W'(count_ext - IDX_W'(2));
      end else if (found_b) begin
         rsp_data_in.peak_index = INDEX_W'(count_ext - IDX_W'(1));
      end else begin
         rsp_data_in.peak_index = '0;
      end

      suppress_in = suppress_ff;
      if (s1_move) begin
         suppress_in = s1_last_ff ? '0 : suppress_mid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("Input stalled while a stage was free.");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last) |=> (count_ff == '0 && window_ff[0] == '0))
      else $error("Frame state not cleared after the final item.");

   assert property (@(posedge clock) disable iff (reset)
      (s1_move && rsp_data_in.peak_found && !s1_last_ff) |=> (suppress_ff == SUPPRESS_SPAN))
      else $error("Suppression not armed after a peak.");

   assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_count_ff < CNT_W'(2)) |-> !rsp_data_in.peak_found)
      else $error("Peak reported for a frame shorter than three samples.");

endmodule
